@@ src/fqt_pkg.sv @@
// ----------------------------------------------------------------------------
// Query tokenizer package
// Shared types, constants and character helpers for the query tokenizer.
// ----------------------------------------------------------------------------
package fqt_pkg;

  localparam int unsigned MAX_WORDS_DEF       = 32;
  localparam int unsigned MAX_QUERY_BYTES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;

  localparam int unsigned CAP_W    = 6;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LENGTH_W = 13;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  localparam int unsigned PREFIX_LEN = 7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    SCAN_BETWEEN = 2'd0,
    SCAN_IN_WORD = 2'd1,
    SCAN_IGNORE  = 2'd2
  } scan_e;

  typedef enum logic [1:0] {
    OP_AND     = 2'd0,
    OP_OR      = 2'd1,
    OP_EXCLUDE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PARAM = 2'd1,
    ST_OVER_CAP  = 2'd2
  } status_e;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] query_char;
    logic       query_end;
  } in_word_t;

  typedef struct packed {
    logic                result_kind;
    logic [1:0]          status;
    logic [INDEX_W-1:0]  word_index;
    logic [OFFSET_W-1:0] word_offset;
    logic [LENGTH_W-1:0] word_length;
    logic [1:0]          operation;
    logic                match_mode;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic                has_word;
    logic [INDEX_W-1:0]  word_index;
    logic [OFFSET_W-1:0] word_offset;
    logic [LENGTH_W-1:0] word_length;
    logic [1:0]          operation;
    logic                match_mode;
    logic                has_status;
    logic [1:0]          status;
  } q_entry_t;

  function automatic logic is_separator(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_FF, CH_BS, CH_COMMA};
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c inside {[CH_UPPER_A:CH_UPPER_Z]}) ? c + CASE_OFFSET : c;
  endfunction

  function automatic logic [7:0] prefix_char(logic [2:0] k);
    logic [7:0] ch;
    case (k)
      3'd0:    ch = 8'h70;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h65;
      3'd3:    ch = 8'h66;
      3'd4:    ch = 8'h69;
      3'd5:    ch = 8'h78;
      3'd6:    ch = CH_COLON;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

@@ src/fqt_front.sv @@
// ----------------------------------------------------------------------------
// Query tokenizer front end
// Scans one byte per cycle unless the queue is full, tracks word and command
// state, and queues the word descriptor and status that each byte causes.
// ----------------------------------------------------------------------------
module fqt_front #(
  parameter int unsigned MAX_WORDS       = fqt_pkg::MAX_WORDS_DEF,
  parameter int unsigned MAX_QUERY_BYTES = fqt_pkg::MAX_QUERY_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  fqt_pkg::in_word_t         in_word_i,
  input  logic                      cfg_we_i,
  input  logic [fqt_pkg::CAP_W-1:0] cfg_data_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output fqt_pkg::q_entry_t         q_entry_o
);

  localparam int unsigned POS_W = $clog2(MAX_QUERY_BYTES + 1);
  localparam int unsigned WF_W  = $clog2(MAX_WORDS + 1);
  localparam int unsigned CMP_W = (WF_W > fqt_pkg::CAP_W) ? WF_W : fqt_pkg::CAP_W;

  fqt_pkg::scan_e            mode_q, mode_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [POS_W-1:0]          wb_q, wb_d;
  logic [POS_W-1:0]          ca_q, ca_d;
  logic                      cs_q, cs_d;
  logic                      pm_q, pm_d;
  fqt_pkg::op_e              op_q, op_d;
  logic [WF_W-1:0]           wf_q, wf_d;
  logic                      held_q, held_d;
  fqt_pkg::status_e          hst_q, hst_d;
  logic [fqt_pkg::CAP_W-1:0] cap_q;

  logic accept;

  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    logic             close_req;
    logic [POS_W-1:0] close_end;
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
    logic [7:0]       c;
    logic [7:0]       lc;
    logic             bad;
    logic             over;
    logic             mm;

    mode_d    = mode_q;
    pos_d     = pos_q;
    wb_d      = wb_q;
    ca_d      = ca_q;
    cs_d      = cs_q;
    pm_d      = pm_q;
    op_d      = op_q;
    wf_d      = wf_q;
    held_d    = held_q;
    hst_d     = hst_q;
    close_req = 1'b0;
    close_end = pos_q;
    q_entry_o = '0;
    c         = in_word_i.query_char;
    lc        = fqt_pkg::to_lower(c);
    k         = pos_q - wb_q;
    start     = '0;
    len       = '0;
    bad       = 1'b0;
    over      = 1'b0;
    mm        = 1'b0;

    if (accept) begin
      if (in_word_i.char_valid && mode_q != fqt_pkg::SCAN_IGNORE) begin
        if (c == fqt_pkg::CH_NUL || pos_q >= POS_W'(MAX_QUERY_BYTES)) begin
          if (mode_q == fqt_pkg::SCAN_IN_WORD) begin
            close_req = 1'b1;
          end
          mode_d = fqt_pkg::SCAN_IGNORE;
        end else begin
          if (fqt_pkg::is_separator(c)) begin
            if (mode_q == fqt_pkg::SCAN_IN_WORD) begin
              close_req = 1'b1;
              mode_d    = fqt_pkg::SCAN_BETWEEN;
            end
          end else if (mode_q == fqt_pkg::SCAN_BETWEEN) begin
            mode_d = fqt_pkg::SCAN_IN_WORD;
            case (c)
              fqt_pkg::CH_PLUS:  op_d = fqt_pkg::OP_AND;
              fqt_pkg::CH_MINUS: op_d = fqt_pkg::OP_EXCLUDE;
              fqt_pkg::CH_PIPE:  op_d = fqt_pkg::OP_OR;
              default:           op_d = fqt_pkg::OP_AND;
            endcase
            if (c inside {fqt_pkg::CH_PLUS, fqt_pkg::CH_MINUS, fqt_pkg::CH_PIPE}) begin
              wb_d = pos_q + 1'b1;
              cs_d = 1'b0;
              ca_d = '0;
              pm_d = 1'b1;
            end else begin
              wb_d = pos_q;
              pm_d = (lc == fqt_pkg::prefix_char(3'd0));
              cs_d = (c == fqt_pkg::CH_COLON);
              ca_d = (c == fqt_pkg::CH_COLON) ? pos_q + 1'b1 : '0;
            end
          end else begin
            if (k < POS_W'(fqt_pkg::PREFIX_LEN) && pm_q &&
                lc != fqt_pkg::prefix_char(k[2:0])) begin
              pm_d = 1'b0;
            end
            if (c == fqt_pkg::CH_COLON && !cs_q) begin
              cs_d = 1'b1;
              ca_d = pos_q + 1'b1;
            end
          end
          pos_d = pos_q + 1'b1;
        end
      end

      if (in_word_i.query_end && mode_d == fqt_pkg::SCAN_IN_WORD) begin
        close_req = 1'b1;
        close_end = pos_d;
      end

      if (close_req) begin
        bad   = (close_end == wb_d) || (cs_d && ca_d == close_end);
        over  = CMP_W'(wf_q) >= CMP_W'(cap_q);
        start = cs_d ? ca_d : wb_d;
        len   = close_end - start;
        mm    = cs_d && pm_d && (ca_d - wb_d == POS_W'(fqt_pkg::PREFIX_LEN));
        if (bad) begin
          held_d = 1'b1;
          hst_d  = fqt_pkg::ST_BAD_PARAM;
          mode_d = fqt_pkg::SCAN_IGNORE;
        end else if (over) begin
          held_d = 1'b1;
          hst_d  = fqt_pkg::ST_OVER_CAP;
          mode_d = fqt_pkg::SCAN_IGNORE;
        end else begin
          q_entry_o.has_word    = 1'b1;
          q_entry_o.word_index  = fqt_pkg::INDEX_W'(wf_q);
          q_entry_o.word_offset = fqt_pkg::OFFSET_W'(start);
          q_entry_o.word_length = fqt_pkg::LENGTH_W'(len);
          q_entry_o.operation   = op_d;
          q_entry_o.match_mode  = mm;
          wf_d = wf_q + 1'b1;
          if (wf_d >= WF_W'(MAX_WORDS)) begin
            held_d = 1'b1;
            hst_d  = fqt_pkg::ST_OK;
            mode_d = fqt_pkg::SCAN_IGNORE;
          end
        end
      end

      if (in_word_i.query_end) begin
        q_entry_o.has_status = 1'b1;
        if (held_d) begin
          q_entry_o.status = hst_d;
        end else if (wf_d == '0) begin
          q_entry_o.status = fqt_pkg::ST_BAD_PARAM;
        end else begin
          q_entry_o.status = fqt_pkg::ST_OK;
        end
        mode_d = fqt_pkg::SCAN_BETWEEN;
        pos_d  = '0;
        wb_d   = '0;
        ca_d   = '0;
        cs_d   = 1'b0;
        pm_d   = 1'b1;
        op_d   = fqt_pkg::OP_AND;
        wf_d   = '0;
        held_d = 1'b0;
        hst_d  = fqt_pkg::ST_OK;
      end
    end
  end

  assign q_push_o = accept && (q_entry_o.has_word || q_entry_o.has_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fqt_pkg::SCAN_BETWEEN;
      pos_q  <= '0;
      wb_q   <= '0;
      ca_q   <= '0;
      cs_q   <= 1'b0;
      pm_q   <= 1'b1;
      op_q   <= fqt_pkg::OP_AND;
      wf_q   <= '0;
      held_q <= 1'b0;
      hst_q  <= fqt_pkg::ST_OK;
      cap_q  <= fqt_pkg::CAP_RESET;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      wb_q   <= wb_d;
      ca_q   <= ca_d;
      cs_q   <= cs_d;
      pm_q   <= pm_d;
      op_q   <= op_d;
      wf_q   <= wf_d;
      held_q <= held_d;
      hst_q  <= hst_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ src/fqt_queue.sv @@
// ----------------------------------------------------------------------------
// Query tokenizer result queue
// Short first-in first-out queue between the scanner and the result formatter.
// ----------------------------------------------------------------------------
module fqt_queue #(
  parameter int unsigned DEPTH = fqt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fqt_pkg::q_entry_t push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output fqt_pkg::q_entry_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fqt_pkg::q_entry_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ src/fqt_back.sv @@
// ----------------------------------------------------------------------------
// Query tokenizer result formatter
// Drains queued entries to the output register, one word per unstalled cycle.
// ----------------------------------------------------------------------------
module fqt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  fqt_pkg::q_entry_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fqt_pkg::out_word_t out_word_o
);

  logic               out_valid_q, out_valid_d;
  fqt_pkg::out_word_t out_q, out_d;
  logic               phase_q, phase_d;
  logic               load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    if (load && q_valid_i) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (head_i.has_word && !phase_q) begin
        out_d.result_kind = fqt_pkg::KIND_WORD;
        out_d.status      = fqt_pkg::ST_OK;
        out_d.word_index  = head_i.word_index;
        out_d.word_offset = head_i.word_offset;
        out_d.word_length = head_i.word_length;
        out_d.operation   = head_i.operation;
        out_d.match_mode  = head_i.match_mode;
        out_d.last        = 1'b0;
        if (head_i.has_status) begin
          phase_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        out_d.result_kind = fqt_pkg::KIND_STATUS;
        out_d.status      = head_i.status;
        out_d.last        = 1'b1;
        phase_d           = 1'b0;
        pop_o             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ src/fulltext_query_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// Full-text query tokenizer
// Splits a search query, one byte per word on the input channel, into word
// descriptors and a closing status word.
//
// Input channel: in_valid_i / in_stall_o carry in_word_i (char_valid,
// query_char, query_end). Output channel: out_valid_o / out_stall_i carry
// out_word_o. A word moves at a clock edge with valid high and stall low.
// cfg_we_i writes cfg_data_i into the word capacity register; write it only
// between queries.
// Throughput: one input word per cycle while in_stall_o is low. An input word
// yields zero, one or two output words; the output register drains one per
// cycle while out_stall_i is low, so a byte that closes a word and ends the
// query yields a descriptor and then a status word. Results pass through a
// four-entry queue between the scanner and the output register. The queue
// absorbs output stalls; in_stall_o rises only while that queue is full.
// Reset clears the query state, empties the queue and sets the capacity
// to 32. The status word ends a query and returns the scanner to its
// initial state.
// ----------------------------------------------------------------------------
module fulltext_query_tokenizer_unit #(
  parameter int unsigned MAX_WORDS       = fqt_pkg::MAX_WORDS_DEF,
  parameter int unsigned MAX_QUERY_BYTES = fqt_pkg::MAX_QUERY_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = fqt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  fqt_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fqt_pkg::out_word_t        out_word_o,
  input  logic                      cfg_we_i,
  input  logic [fqt_pkg::CAP_W-1:0] cfg_data_i
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  fqt_pkg::q_entry_t q_push_entry;
  fqt_pkg::q_entry_t q_head;

  assign in_stall_o = q_full;

  fqt_front #(
    .MAX_WORDS       (MAX_WORDS),
    .MAX_QUERY_BYTES (MAX_QUERY_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_push_entry)
  );

  fqt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  fqt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ bench/fqt_token_checker.sv @@
// ----------------------------------------------------------------------------
// Query tokenizer checker
// Watches the input, output and capacity ports of the query tokenizer. Keeps
// its own model of the scanner. Queues the descriptor and status words that
// each accepted byte word should produce. Compares every accepted output word
// field by field against the oldest queued word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fqt_token_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  fqt_pkg::in_word_t         in_word_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  fqt_pkg::out_word_t        out_word_i,
  input  logic                      cfg_we_i,
  input  logic [fqt_pkg::CAP_W-1:0] cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        descriptors_o,
  output int                        statuses_o
);

  localparam logic [55:0] PREFIX_CMD = "prefix:";

  logic [fqt_pkg::CAP_W-1:0] capacity;
  fqt_pkg::scan_e            scan;
  int unsigned               pos;
  int unsigned               begin_at;
  int unsigned               colon_at;
  bit                        colon_hit;
  bit                        prefix_ok;
  fqt_pkg::op_e              pend_op;
  int unsigned               found;
  bit                        held;
  fqt_pkg::status_e          held_st;
  fqt_pkg::out_word_t        token_q[$];
  int                        mismatches = 0;
  int                        descriptors = 0;
  int                        statuses = 0;

  task automatic clear_query();
    scan      = fqt_pkg::SCAN_BETWEEN;
    pos       = 0;
    begin_at  = 0;
    colon_at  = 0;
    colon_hit = 1'b0;
    prefix_ok = 1'b1;
    pend_op   = fqt_pkg::OP_AND;
    found     = 0;
    held      = 1'b0;
    held_st   = fqt_pkg::ST_OK;
  endtask

  task automatic take_byte(logic [7:0] c);
    int unsigned k;
    logic [7:0]  lc;
    k  = pos - begin_at;
    lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    if (k < fqt_pkg::PREFIX_LEN && prefix_ok && lc != PREFIX_CMD[8*(6-k) +: 8])
      prefix_ok = 1'b0;
    if (c == fqt_pkg::CH_COLON && !colon_hit) begin
      colon_hit = 1'b1;
      colon_at  = pos + 1;
    end
  endtask

  task automatic open_word(logic [7:0] c);
    scan      = fqt_pkg::SCAN_IN_WORD;
    colon_hit = 1'b0;
    colon_at  = 0;
    prefix_ok = 1'b1;
    if (c == fqt_pkg::CH_PLUS || c == fqt_pkg::CH_MINUS || c == fqt_pkg::CH_PIPE) begin
      pend_op  = (c == fqt_pkg::CH_PIPE) ? fqt_pkg::OP_OR :
                 (c == fqt_pkg::CH_MINUS) ? fqt_pkg::OP_EXCLUDE : fqt_pkg::OP_AND;
      begin_at = pos + 1;
    end else begin
      pend_op  = fqt_pkg::OP_AND;
      begin_at = pos;
      take_byte(c);
    end
  endtask

  task automatic stop_query(fqt_pkg::status_e st);
    held    = 1'b1;
    held_st = st;
    scan    = fqt_pkg::SCAN_IGNORE;
  endtask

  task automatic close_word(int unsigned stop);
    int unsigned        start;
    fqt_pkg::out_word_t d;
    if (stop == begin_at || (colon_hit && colon_at == stop)) begin
      stop_query(fqt_pkg::ST_BAD_PARAM);
    end else if (found >= capacity) begin
      stop_query(fqt_pkg::ST_OVER_CAP);
    end else begin
      start         = colon_hit ? colon_at : begin_at;
      d             = '0;
      d.result_kind = fqt_pkg::KIND_WORD;
      d.status      = fqt_pkg::ST_OK;
      d.word_index  = found[fqt_pkg::INDEX_W-1:0];
      d.word_offset = start[fqt_pkg::OFFSET_W-1:0];
      d.word_length = fqt_pkg::LENGTH_W'(stop - start);
      d.operation   = pend_op;
      d.match_mode  = colon_hit && prefix_ok &&
                      (colon_at - begin_at == fqt_pkg::PREFIX_LEN);
      token_q.push_back(d);
      found++;
      if (found >= fqt_pkg::MAX_WORDS_DEF) stop_query(fqt_pkg::ST_OK);
      else scan = fqt_pkg::SCAN_BETWEEN;
    end
  endtask

  task automatic predict_word(fqt_pkg::in_word_t w);
    fqt_pkg::out_word_t s;
    if (w.char_valid && scan != fqt_pkg::SCAN_IGNORE) begin
      if (w.query_char == fqt_pkg::CH_NUL || pos >= fqt_pkg::MAX_QUERY_BYTES_DEF) begin
        if (scan == fqt_pkg::SCAN_IN_WORD) close_word(pos);
        scan = fqt_pkg::SCAN_IGNORE;
      end else begin
        if (w.query_char inside {fqt_pkg::CH_SPACE, fqt_pkg::CH_TAB, fqt_pkg::CH_CR,
                                 fqt_pkg::CH_LF, fqt_pkg::CH_FF, fqt_pkg::CH_BS,
                                 fqt_pkg::CH_COMMA}) begin
          if (scan == fqt_pkg::SCAN_IN_WORD) close_word(pos);
        end else if (scan == fqt_pkg::SCAN_BETWEEN) begin
          open_word(w.query_char);
        end else begin
          take_byte(w.query_char);
        end
        pos++;
      end
    end
    if (w.query_end) begin
      if (scan == fqt_pkg::SCAN_IN_WORD) close_word(pos);
      s             = '0;
      s.result_kind = fqt_pkg::KIND_STATUS;
      s.status      = held ? held_st :
                      (found == 0) ? fqt_pkg::ST_BAD_PARAM : fqt_pkg::ST_OK;
      s.last        = 1'b1;
      token_q.push_back(s);
      clear_query();
    end
  endtask

  task automatic check_field(string name, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(fqt_pkg::out_word_t got);
    fqt_pkg::out_word_t want;
    if (token_q.size() == 0) begin
      $error("result word with nothing expected: kind %0d status %0d index %0d",
             got.result_kind, got.status, got.word_index);
      mismatches++;
    end else begin
      want = token_q.pop_front();
      if (want.result_kind == fqt_pkg::KIND_WORD) descriptors++;
      else statuses++;
      check_field("result_kind", 13'(want.result_kind), 13'(got.result_kind));
      check_field("status", 13'(want.status), 13'(got.status));
      check_field("word_index", 13'(want.word_index), 13'(got.word_index));
      check_field("word_offset", 13'(want.word_offset), 13'(got.word_offset));
      check_field("word_length", want.word_length, got.word_length);
      check_field("operation", 13'(want.operation), 13'(got.operation));
      check_field("match_mode", 13'(want.match_mode), 13'(got.match_mode));
      check_field("last", 13'(want.last), 13'(got.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity = fqt_pkg::CAP_RESET;
      clear_query();
      token_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_word_i);
      if (cfg_we_i) capacity = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_word(in_word_i);
      pending_o <= token_q.size();
    end
    fail_count_o  <= mismatches;
    descriptors_o <= descriptors;
    statuses_o    <= statuses;
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Query tokenizer testbench
// Feeds the tokenizer a short set of hand-written queries, then random queries
// under a range of word capacities. The sender pauses between bursts and the
// receiver stalls on its own pattern. The checker beside the block predicts
// and compares every output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASE_WORDS  = 100;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  fqt_pkg::in_word_t         in_word = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  fqt_pkg::out_word_t        out_word;
  logic                      cfg_we = 1'b0;
  logic [fqt_pkg::CAP_W-1:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          descriptors;
  int          statuses;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned queries = 0;
  int unsigned settings = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  bit          no_gaps = 1'b0;
  bit          steady = 1'b0;

  fulltext_query_tokenizer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  fqt_token_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .descriptors_o (descriptors),
    .statuses_o    (statuses)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (steady || !rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      stall_left = $urandom_range(0, 8);
      free_left  = $urandom_range(1, 12);
      out_stall <= 1'b0;
    end
  end

  task automatic push_word(logic cv, logic [7:0] ch, logic qe);
    if (burst_left == 0) begin
      if (!no_gaps && $urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_word  <= '{char_valid: cv, query_char: ch, query_end: qe};
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    if (qe) queries++;
  endtask

  task automatic push_text(string s, bit end_last);
    for (int i = 0; i < s.len(); i++) push_word(1'b1, s[i], end_last && i == s.len() - 1);
  endtask

  // occasionally slip in a word that carries no byte
  task automatic push_byte(logic [7:0] c);
    if ($urandom_range(0, 15) == 0) push_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
    push_word(1'b1, c, 1'b0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [fqt_pkg::CAP_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 6))
      0: return fqt_pkg::CH_SPACE;
      1: return fqt_pkg::CH_TAB;
      2: return fqt_pkg::CH_CR;
      3: return fqt_pkg::CH_LF;
      4: return fqt_pkg::CH_FF;
      5: return fqt_pkg::CH_BS;
      default: return fqt_pkg::CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'($urandom_range(1, 255));
    if (r == 1) return fqt_pkg::CH_COLON;
    if (r < 6) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic string pick_command();
    case ($urandom_range(0, 7))
      0: return "prefix:";
      1: return "PREFIX:";
      2: return "PrEfIx:";
      3: return "complete:";
      4: return "pre:";
      5: return ":";
      6: return "prefixes:";
      default: return "prefix";
    endcase
  endfunction

  task automatic random_query();
    int unsigned n_words;
    int unsigned len;
    string       cmd;
    no_gaps = ($urandom_range(0, 3) == 0);
    steady <= no_gaps;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10))
        push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
    end else begin
      n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
      for (int w = 0; w < n_words; w++) begin
        if (w > 0 || $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) push_byte(pick_separator());
        case ($urandom_range(0, 5))
          0: push_byte(fqt_pkg::CH_PLUS);
          1: push_byte(fqt_pkg::CH_MINUS);
          2: push_byte(fqt_pkg::CH_PIPE);
          default: ;
        endcase
        if ($urandom_range(0, 2) == 0) begin
          cmd = pick_command();
          for (int i = 0; i < cmd.len(); i++) push_byte(cmd[i]);
        end
        len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
        repeat (len) push_byte(pick_text_byte());
      end
      case ($urandom_range(0, 3))
        0: push_word(1'b1, pick_text_byte(), 1'b1);
        1: push_word(1'b1, pick_separator(), 1'b1);
        2: push_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        default: begin
          push_byte(fqt_pkg::CH_NUL);
          repeat ($urandom_range(0, 3)) push_byte(pick_text_byte());
          push_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
    end
  endtask

  initial begin
    logic [fqt_pkg::CAP_W-1:0] caps [8];
    int unsigned               goal;
    caps = '{6'd1, 6'd63, 6'd0, 6'd32, 6'd2, 6'd17, 6'd0, 6'd0};
    caps[6] = fqt_pkg::CAP_W'($urandom_range(1, 32));
    caps[7] = fqt_pkg::CAP_W'($urandom_range(1, 32));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_text("+a -PrEfIx:b |:c", 1'b1);
    push_word(1'b0, 8'hFF, 1'b1);
    push_text("-", 1'b1);
    push_text("x:", 1'b1);
    push_word(1'b1, "a", 1'b0);
    push_word(1'b1, fqt_pkg::CH_NUL, 1'b0);
    push_word(1'b1, "b", 1'b1);
    push_word(1'b1, fqt_pkg::CH_TAB, 1'b1);
    settle();
    write_capacity(6'd1);
    push_text("u,v", 1'b1);

    foreach (caps[i]) begin
      settle();
      write_capacity(caps[i]);
      goal = items_sent + PHASE_WORDS;
      while (items_sent < goal) random_query();
    end
    settle();

    $display("Run covered %0d input words in %0d queries over %0d capacity settings,",
             items_sent, queries, settings + 1);
    $display("with %0d word descriptors and %0d status words compared.",
             descriptors, statuses);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ fulltext_query_tokenizer_unit.f @@
src/fqt_pkg.sv
src/fqt_front.sv
src/fqt_queue.sv
src/fqt_back.sv
src/fulltext_query_tokenizer_unit.sv
bench/fqt_token_checker.sv
bench/tb.sv
